/* rtl/cta_pkg.sv */
// shared types, codes and default geometry for the tower adjacency core
package cta_pkg;

    localparam int ID_W  = 16;
    localparam int REL_W = 2;

    // default geometry
    localparam int TOWERS_PER_CRATE_DEF    = 128;
    localparam int CRATES_PER_SECTOR_DEF   = 6;
    localparam int SECTORS_PER_CHAMBER_DEF = 25;
    localparam int CHAMBERS_DEF            = 2;

    // reciprocal scaling for the constant dividers
    localparam int RECIP_SHIFT = 32;

    typedef enum logic [REL_W-1:0] {
        REL_CONTINUE  = 2'd0,
        REL_NEIGHBOUR = 2'd1,
        REL_STOP      = 2'd2,
        REL_BEFORE    = 2'd3
    } relation_t;

    typedef enum logic {
        OP_SIDE   = 1'b0,
        OP_VERTEX = 1'b1
    } operation_t;

    // per-stage load enables of the decode pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

/* rtl/cta_decode.sv */
// three-stage tower id decoder: reciprocal estimate, correction, field split
module cta_decode #(
    parameter int TOWERS_PER_CRATE    = cta_pkg::TOWERS_PER_CRATE_DEF,
    parameter int CRATES_PER_SECTOR   = cta_pkg::CRATES_PER_SECTOR_DEF,
    parameter int SECTORS_PER_CHAMBER = cta_pkg::SECTORS_PER_CHAMBER_DEF,
    parameter int CH_W                = 1,
    parameter int SEC_W               = 5,
    parameter int PHI_W               = 4,
    parameter int Z_W                 = 6
) (
    input  logic                      clk,
    input  cta_pkg::stage_en_t        en,
    input  logic [cta_pkg::ID_W-1:0]  id,
    output logic [CH_W-1:0]           ch,
    output logic [SEC_W-1:0]          sec,
    output logic [PHI_W-1:0]          phi,
    output logic [Z_W-1:0]            z
);

    localparam int ID_W   = cta_pkg::ID_W;
    localparam int PROD_W = ID_W + cta_pkg::RECIP_SHIFT;

    localparam int DIV_CR  = TOWERS_PER_CRATE;
    localparam int DIV_SEC = TOWERS_PER_CRATE * CRATES_PER_SECTOR;
    localparam int DIV_CH  = DIV_SEC * SECTORS_PER_CHAMBER;

    localparam logic [31:0] RECIP_CR  = 32'((64'd1 << cta_pkg::RECIP_SHIFT) / DIV_CR);
    localparam logic [31:0] RECIP_SEC = 32'((64'd1 << cta_pkg::RECIP_SHIFT) / DIV_SEC);
    localparam logic [31:0] RECIP_CH  = 32'((64'd1 << cta_pkg::RECIP_SHIFT) / DIV_CH);

    // stage 1: quotient estimates, low by at most one
    logic [PROD_W-1:0] p_cr, p_sec, p_ch;
    logic [ID_W-1:0]   e_cr_reg, e_sec_reg, e_ch_reg, id1_reg;

    assign p_cr  = PROD_W'(id) * PROD_W'(RECIP_CR);
    assign p_sec = PROD_W'(id) * PROD_W'(RECIP_SEC);
    assign p_ch  = PROD_W'(id) * PROD_W'(RECIP_CH);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            e_cr_reg  <= p_cr[PROD_W-1:cta_pkg::RECIP_SHIFT];
            e_sec_reg <= p_sec[PROD_W-1:cta_pkg::RECIP_SHIFT];
            e_ch_reg  <= p_ch[PROD_W-1:cta_pkg::RECIP_SHIFT];
            id1_reg   <= id;
        end
    end

    // stage 2: remainder check and correction
    logic [31:0]     r_cr, r_sec, r_ch;
    logic [ID_W-1:0] q_cr_next, q_sec_next, q_ch_next;
    logic [ID_W-1:0] q_cr_reg, q_sec_reg, q_ch_reg, id2_reg;

    always_comb
    begin
        r_cr  = 32'(id1_reg) - 32'(e_cr_reg) * 32'(DIV_CR);
        r_sec = 32'(id1_reg) - 32'(e_sec_reg) * 32'(DIV_SEC);
        r_ch  = 32'(id1_reg) - 32'(e_ch_reg) * 32'(DIV_CH);
        q_cr_next  = e_cr_reg + ID_W'(r_cr >= 32'(DIV_CR));
        q_sec_next = e_sec_reg + ID_W'(r_sec >= 32'(DIV_SEC));
        q_ch_next  = e_ch_reg + ID_W'(r_ch >= 32'(DIV_CH));
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            q_cr_reg  <= q_cr_next;
            q_sec_reg <= q_sec_next;
            q_ch_reg  <= q_ch_next;
            id2_reg   <= id1_reg;
        end
    end

    // stage 3: local sector, crate and offset from the global quotients
    logic [31:0] sec_full, crate_full, off_full, phi_full;
    logic [CH_W-1:0]  ch_reg;
    logic [SEC_W-1:0] sec_reg;
    logic [PHI_W-1:0] phi_reg;
    logic [Z_W-1:0]   z_reg;

    always_comb
    begin
        sec_full   = 32'(q_sec_reg) - 32'(q_ch_reg) * 32'(SECTORS_PER_CHAMBER);
        crate_full = 32'(q_cr_reg) - 32'(q_sec_reg) * 32'(CRATES_PER_SECTOR);
        off_full   = 32'(id2_reg) - 32'(q_cr_reg) * 32'(TOWERS_PER_CRATE);
        phi_full   = (crate_full << 1) + 32'(off_full[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            ch_reg  <= q_ch_reg[CH_W-1:0];
            sec_reg <= sec_full[SEC_W-1:0];
            phi_reg <= phi_full[PHI_W-1:0];
            z_reg   <= off_full[Z_W:1];
        end
    end

    assign ch  = ch_reg;
    assign sec = sec_reg;
    assign phi = phi_reg;
    assign z   = z_reg;

endmodule

/* rtl/cta_compare.sv */
// side and corner adjacency decision on two decoded towers
module cta_compare #(
    parameter int CRATES_PER_SECTOR   = cta_pkg::CRATES_PER_SECTOR_DEF,
    parameter int SECTORS_PER_CHAMBER = cta_pkg::SECTORS_PER_CHAMBER_DEF,
    parameter int CH_W                = 1,
    parameter int SEC_W               = 5,
    parameter int PHI_W               = 4,
    parameter int Z_W                 = 6
) (
    input  cta_pkg::operation_t op,
    input  logic                mode,
    input  logic [CH_W-1:0]     a_ch,
    input  logic [SEC_W-1:0]    a_sec,
    input  logic [PHI_W-1:0]    a_phi,
    input  logic [Z_W-1:0]      a_z,
    input  logic [CH_W-1:0]     b_ch,
    input  logic [SEC_W-1:0]    b_sec,
    input  logic [PHI_W-1:0]    b_phi,
    input  logic [Z_W-1:0]      b_z,
    output cta_pkg::relation_t  rel
);

    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTORS_PER_CHAMBER - 1);
    localparam logic [PHI_W-1:0] LAST_PHI = PHI_W'(2 * CRATES_PER_SECTOR - 1);

    logic phi_eq, phi_d1, z_eq, z_d1, side_adj, b_phi_far;
    logic b_prec_a, a_prec_b, a_phi_first, a_phi_last;

    always_comb
    begin
        phi_eq = (a_phi == b_phi);
        z_eq   = (a_z == b_z);
        phi_d1 = phi_eq || ({1'b0, a_phi} + 1'b1 == {1'b0, b_phi})
                        || ({1'b0, b_phi} + 1'b1 == {1'b0, a_phi});
        z_d1   = z_eq || ({1'b0, a_z} + 1'b1 == {1'b0, b_z})
                      || ({1'b0, b_z} + 1'b1 == {1'b0, a_z});
        side_adj  = (phi_d1 && z_eq) || (phi_eq && z_d1);
        b_phi_far = {1'b0, b_phi} > {1'b0, a_phi} + 1'b1;
        // sector wrap: sector 0 follows the last sector
        b_prec_a  = (a_sec == '0) ? (b_sec == LAST_SEC) : ({1'b0, b_sec} + 1'b1 == {1'b0, a_sec});
        a_prec_b  = (b_sec == '0) ? (a_sec == LAST_SEC) : ({1'b0, a_sec} + 1'b1 == {1'b0, b_sec});
        a_phi_first = (a_phi == '0);
        a_phi_last  = (a_phi == LAST_PHI);
    end

    always_comb
    begin
        rel = cta_pkg::REL_CONTINUE;
        if (op == cta_pkg::OP_SIDE)
        begin
            priority if (a_ch > b_ch)
                rel = cta_pkg::REL_BEFORE;
            else if (a_ch < b_ch)
                rel = cta_pkg::REL_STOP;
            else if (mode)
            begin
                priority if (a_sec == b_sec)
                    rel = side_adj ? cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
                else if (b_prec_a)
                    rel = (a_phi_first && b_phi == LAST_PHI && z_eq) ?
                          cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
                else if (a_prec_b)
                begin
                    if (a_phi_last)
                        rel = (b_phi == '0 && z_eq) ?
                              cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
                    else
                        rel = (!a_phi_first && b_sec > a_sec) ?
                              cta_pkg::REL_STOP : cta_pkg::REL_CONTINUE;
                end
                else
                    rel = (!a_phi_first && !a_phi_last && b_sec > a_sec) ?
                          cta_pkg::REL_STOP : cta_pkg::REL_CONTINUE;
            end
            else if (a_sec > b_sec)
                rel = cta_pkg::REL_BEFORE;
            else if (a_sec < b_sec)
                rel = cta_pkg::REL_STOP;
            else if (side_adj)
                rel = cta_pkg::REL_NEIGHBOUR;
            else if (b_phi_far)
                rel = cta_pkg::REL_STOP;
            else
                rel = cta_pkg::REL_CONTINUE;
        end
        else
        begin
            priority if (a_ch != b_ch)
                rel = cta_pkg::REL_CONTINUE;
            else if (a_sec == b_sec)
                rel = (phi_d1 && z_d1) ? cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
            else if (!mode)
                rel = cta_pkg::REL_CONTINUE;
            else if (b_prec_a)
                rel = (a_phi_first && b_phi == LAST_PHI && z_d1) ?
                      cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
            else if (a_prec_b)
                rel = (a_phi_last && b_phi == '0 && z_d1) ?
                      cta_pkg::REL_NEIGHBOUR : cta_pkg::REL_CONTINUE;
            else
                rel = cta_pkg::REL_CONTINUE;
        end
    end

endmodule

/* rtl/calorimeter_tower_adjacency_core.sv */
// top level of the calorimeter tower adjacency core
//
// usage:
//   input channel in_valid/in_ready carries one item: operation (0 side test,
//   1 corner test) and two absolute tower ids; output channel
//   out_valid/out_ready returns one relation code per item, in order
//   relation: 0 continue, 1 neighbour, 2 stop searching, 3 second precedes first
//   cfg_we/cfg_wdata write the multi-sector mode bit (wrap across sector edges);
//   write it only while no item is in flight
// timing:
//   four register stages: reciprocal multiply, quotient correction, field
//   split, relation decision into the output register; throughput one item
//   per cycle while out_ready keeps the output register draining
// reset:
//   rst_n clears all stage valid bits and the mode bit (single-sector mode)
// stalls:
//   each stage holds while the stage after it is full and cannot move, so
//   bubbles close up and in_ready stays high as long as any stage is free;
//   nothing is dropped or duplicated under back-pressure
module calorimeter_tower_adjacency_core #(
    parameter int TOWERS_PER_CRATE    = cta_pkg::TOWERS_PER_CRATE_DEF,
    parameter int CRATES_PER_SECTOR   = cta_pkg::CRATES_PER_SECTOR_DEF,
    parameter int SECTORS_PER_CHAMBER = cta_pkg::SECTORS_PER_CHAMBER_DEF,
    parameter int CHAMBERS            = cta_pkg::CHAMBERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [cta_pkg::ID_W-1:0]       first_tower_id,
    input  logic [cta_pkg::ID_W-1:0]       second_tower_id,
    // output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cta_pkg::REL_W-1:0]      relation
);

    // geometry-derived field widths; ids past the last chamber keep the full
    // chamber quotient, so its width follows the id range, not CHAMBERS
    localparam int TOWERS_PER_CHAMBER = TOWERS_PER_CRATE * CRATES_PER_SECTOR
                                        * SECTORS_PER_CHAMBER;
    localparam int CH_MAX   = ((1 << cta_pkg::ID_W) - 1) / TOWERS_PER_CHAMBER;
    localparam int CH_W     = (CH_MAX > 0) ? $clog2(CH_MAX + 1) : 1;
    localparam int SEC_W    = $clog2(SECTORS_PER_CHAMBER);
    localparam int PHI_W    = $clog2(2 * CRATES_PER_SECTOR);
    localparam int Z_CNT    = (TOWERS_PER_CRATE - 1) / 2 + 1;
    localparam int Z_W      = (Z_CNT > 1) ? $clog2(Z_CNT) : 1;
    // nominal chamber count only bounds well-formed ids
    localparam int NOM_CH_W = (CHAMBERS > 1) ? $clog2(CHAMBERS) : 1;

    // mode register
    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    // pipeline flow control: a stage loads when it is empty or drains
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    cta_pkg::stage_en_t en;

    assign adv4 = !v4_reg || out_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign en.s1 = adv1;
    assign en.s2 = adv2;
    assign en.s3 = adv3;

    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // operation travels alongside the decode stages
    cta_pkg::operation_t op1_reg, op2_reg, op3_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
            op1_reg <= cta_pkg::operation_t'(operation);
        if (adv2)
            op2_reg <= op1_reg;
        if (adv3)
            op3_reg <= op2_reg;
    end

    // decoders for both towers
    logic [CH_W-1:0]  a_ch, b_ch;
    logic [SEC_W-1:0] a_sec, b_sec;
    logic [PHI_W-1:0] a_phi, b_phi;
    logic [Z_W-1:0]   a_z, b_z;

    cta_decode #(
        .TOWERS_PER_CRATE    (TOWERS_PER_CRATE),
        .CRATES_PER_SECTOR   (CRATES_PER_SECTOR),
        .SECTORS_PER_CHAMBER (SECTORS_PER_CHAMBER),
        .CH_W                (CH_W),
        .SEC_W               (SEC_W),
        .PHI_W               (PHI_W),
        .Z_W                 (Z_W)
    ) u_decode_first (
        .clk (clk),
        .en  (en),
        .id  (first_tower_id),
        .ch  (a_ch),
        .sec (a_sec),
        .phi (a_phi),
        .z   (a_z)
    );

    cta_decode #(
        .TOWERS_PER_CRATE    (TOWERS_PER_CRATE),
        .CRATES_PER_SECTOR   (CRATES_PER_SECTOR),
        .SECTORS_PER_CHAMBER (SECTORS_PER_CHAMBER),
        .CH_W                (CH_W),
        .SEC_W               (SEC_W),
        .PHI_W               (PHI_W),
        .Z_W                 (Z_W)
    ) u_decode_second (
        .clk (clk),
        .en  (en),
        .id  (second_tower_id),
        .ch  (b_ch),
        .sec (b_sec),
        .phi (b_phi),
        .z   (b_z)
    );

    // relation decision into the output register
    cta_pkg::relation_t rel_next, rel_reg;

    cta_compare #(
        .CRATES_PER_SECTOR   (CRATES_PER_SECTOR),
        .SECTORS_PER_CHAMBER (SECTORS_PER_CHAMBER),
        .CH_W                (CH_W),
        .SEC_W               (SEC_W),
        .PHI_W               (PHI_W),
        .Z_W                 (Z_W)
    ) u_compare (
        .op    (op3_reg),
        .mode  (mode_reg),
        .a_ch  (a_ch),
        .a_sec (a_sec),
        .a_phi (a_phi),
        .a_z   (a_z),
        .b_ch  (b_ch),
        .b_sec (b_sec),
        .b_phi (b_phi),
        .b_z   (b_z),
        .rel   (rel_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv4)
            rel_reg <= rel_next;
    end

    assign out_valid = v4_reg;
    assign relation  = rel_reg;

    // assertions

    // a corner test only ever reports continue or neighbour
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && op3_reg == cta_pkg::OP_VERTEX |->
            rel_next == cta_pkg::REL_CONTINUE || rel_next == cta_pkg::REL_NEIGHBOUR)
        else $error("corner test produced a side-only code");

    // an empty first stage always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> in_ready)
        else $error("input stalled with a free first stage");

    // a full, stalled pipeline must refuse input
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && v4_reg && !out_ready |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

    // an accepted item occupies the first stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted item lost at first stage");

    // a held result keeps its stage-3 source from being overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !out_ready && v3_reg |=> v3_reg && $stable(a_ch) && $stable(b_sec))
        else $error("stage 3 changed while blocked");

    // well-formed geometry: nominal chamber field is at most two bits wider than the chamber quotient
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> NOM_CH_W <= CH_W + 2)
        else $error("chamber width inconsistent with geometry");

endmodule
